// File: rtl/rbp_pkg.sv
package rbp_pkg;

	localparam int LINE_PIXELS = 1024;
	localparam int FRAME_LINES = 1024;

	localparam int PIX_W   = 16;
	localparam int ORG_W   = 10;
	localparam int SIDE_W  = 11;
	localparam int CNT_W   = 10;
	localparam int POS_W   = 11;
	localparam int WIDX_W  = 19;
	localparam int WORD_W  = 2 * PIX_W;
	localparam int HE_W    = 2;
	localparam int CFG_W   = 11;
	localparam int CMP_W   = 14;

	localparam int LIN_RAW = POS_W + $clog2(LINE_PIXELS + 1) + 1;
	localparam int LIN_W   = (LIN_RAW > WIDX_W + 1) ? LIN_RAW : WIDX_W + 1;

	localparam logic [SIDE_W-1:0] MAX_SIDE = SIDE_W'(1024);

	localparam logic [HE_W-1:0] HE_LOW  = 2'b01;
	localparam logic [HE_W-1:0] HE_HIGH = 2'b10;
	localparam logic [HE_W-1:0] HE_BOTH = 2'b11;

	typedef enum logic [1:0] {
		CFG_ORIGIN_X    = 2'd0,
		CFG_ORIGIN_Y    = 2'd1,
		CFG_RECT_WIDTH  = 2'd2,
		CFG_RECT_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [PIX_W-1:0] pixel;
		logic [PIX_W-1:0] held_pixel;
		logic             pair;
		logic             emit;
		logic             last;
	} stage_t;

endpackage

// File: rtl/rbp_pixel_if.sv
interface rbp_pixel_if;
	logic                        valid;
	logic                        ready;
	logic [rbp_pkg::PIX_W-1:0]   pixel_value;
	logic                        first_pixel;

	modport source (output valid, output pixel_value, output first_pixel, input ready);
	modport sink (input valid, input pixel_value, input first_pixel, output ready);
endinterface

// File: rtl/rbp_word_if.sv
interface rbp_word_if;
	logic                        valid;
	logic                        ready;
	logic [rbp_pkg::WIDX_W-1:0]  word_index;
	logic [rbp_pkg::WORD_W-1:0]  word_data;
	logic [rbp_pkg::HE_W-1:0]    half_enable;
	logic                        outside_frame;
	logic                        last_write;

	modport source (output valid, output word_index, output word_data, output half_enable,
		output outside_frame, output last_write, input ready);
	modport sink (input valid, input word_index, input word_data, input half_enable,
		input outside_frame, input last_write, output ready);
endinterface

// File: rtl/rbp_walker.sv
module rbp_walker (
	input  logic                        clk,
	input  logic                        arst_n,
	rbp_pixel_if.sink                   pixels,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [rbp_pkg::CFG_W-1:0]   cfg_data,
	output logic                        stage_valid,
	input  logic                        stage_ready,
	output rbp_pkg::stage_t             stage
);

	logic [rbp_pkg::ORG_W-1:0]  origin_x_q;
	logic [rbp_pkg::ORG_W-1:0]  origin_y_q;
	logic [rbp_pkg::SIDE_W-1:0] rect_width_q;
	logic [rbp_pkg::SIDE_W-1:0] rect_height_q;

	logic [rbp_pkg::CNT_W-1:0]  col_cnt_q;
	logic [rbp_pkg::CNT_W-1:0]  row_cnt_q;
	logic [rbp_pkg::PIX_W-1:0]  held_pixel_q;
	logic                       held_valid_q;

	logic                       valid_s1;
	rbp_pkg::stage_t            stage_s1;

	logic [rbp_pkg::SIDE_W-1:0] w;
	logic [rbp_pkg::SIDE_W-1:0] h;
	logic [rbp_pkg::CNT_W-1:0]  cc;
	logic [rbp_pkg::CNT_W-1:0]  rc;
	logic                       hv;
	logic [rbp_pkg::POS_W-1:0]  col;
	logic [rbp_pkg::POS_W-1:0]  row;
	logic                       row_end;
	logic                       rect_end;
	logic                       odd;
	logic                       take;

	always_comb begin
		if (rect_width_q == '0) begin
			w = rbp_pkg::SIDE_W'(1);
		end else if (rect_width_q > rbp_pkg::MAX_SIDE) begin
			w = rbp_pkg::MAX_SIDE;
		end else begin
			w = rect_width_q;
		end
		if (rect_height_q == '0) begin
			h = rbp_pkg::SIDE_W'(1);
		end else if (rect_height_q > rbp_pkg::MAX_SIDE) begin
			h = rbp_pkg::MAX_SIDE;
		end else begin
			h = rect_height_q;
		end
	end

	assign cc       = pixels.first_pixel ? '0 : col_cnt_q;
	assign rc       = pixels.first_pixel ? '0 : row_cnt_q;
	assign hv       = pixels.first_pixel ? 1'b0 : held_valid_q;
	assign col      = rbp_pkg::POS_W'(origin_x_q) + rbp_pkg::POS_W'(cc);
	assign row      = rbp_pkg::POS_W'(origin_y_q) + rbp_pkg::POS_W'(rc);
	assign row_end  = (rbp_pkg::SIDE_W'(cc) + rbp_pkg::SIDE_W'(1)) >= w;
	assign rect_end = row_end && ((rbp_pkg::SIDE_W'(rc) + rbp_pkg::SIDE_W'(1)) >= h);
	assign odd      = col[0];

	assign pixels.ready = !valid_s1 || stage_ready;
	assign take         = pixels.valid && pixels.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q    <= '0;
			origin_y_q    <= '0;
			rect_width_q  <= rbp_pkg::SIDE_W'(1);
			rect_height_q <= rbp_pkg::SIDE_W'(1);
		end else if (cfg_we) begin
			unique case (rbp_pkg::cfg_reg_t'(cfg_index))
				rbp_pkg::CFG_ORIGIN_X:    origin_x_q    <= cfg_data[rbp_pkg::ORG_W-1:0];
				rbp_pkg::CFG_ORIGIN_Y:    origin_y_q    <= cfg_data[rbp_pkg::ORG_W-1:0];
				rbp_pkg::CFG_RECT_WIDTH:  rect_width_q  <= cfg_data[rbp_pkg::SIDE_W-1:0];
				rbp_pkg::CFG_RECT_HEIGHT: rect_height_q <= cfg_data[rbp_pkg::SIDE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q    <= '0;
			row_cnt_q    <= '0;
			held_valid_q <= 1'b0;
			valid_s1     <= 1'b0;
		end else begin
			if (take) begin
				valid_s1     <= 1'b1;
				held_valid_q <= !odd && !row_end;
				if (row_end) begin
					col_cnt_q <= '0;
					row_cnt_q <= rect_end ? '0 : rc + rbp_pkg::CNT_W'(1);
				end else begin
					col_cnt_q <= cc + rbp_pkg::CNT_W'(1);
					row_cnt_q <= rc;
				end
			end else if (stage_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			if (!odd && !row_end) begin
				held_pixel_q <= pixels.pixel_value;
			end
			stage_s1.col        <= col;
			stage_s1.row        <= row;
			stage_s1.pixel      <= pixels.pixel_value;
			stage_s1.held_pixel <= held_pixel_q;
			stage_s1.pair       <= odd && hv;
			stage_s1.emit       <= odd || row_end;
			stage_s1.last       <= rect_end;
		end
	end

	assign stage_valid = valid_s1;
	assign stage       = stage_s1;

endmodule

// File: rtl/rbp_packer.sv
module rbp_packer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            stage_valid,
	output logic            stage_ready,
	input  rbp_pkg::stage_t stage,
	rbp_word_if.source      words
);

	logic                       out_valid_q;
	logic [rbp_pkg::WIDX_W-1:0] word_index_q;
	logic [rbp_pkg::WORD_W-1:0] word_data_q;
	logic [rbp_pkg::HE_W-1:0]   half_enable_q;
	logic                       outside_q;
	logic                       last_q;

	logic [rbp_pkg::LIN_W-1:0]  lin;
	logic [rbp_pkg::POS_W-1:0]  col_prev;
	logic                       out_cur;
	logic                       out_prev;
	logic                       odd;
	logic                       move;
	logic [rbp_pkg::WORD_W-1:0] data;
	logic [rbp_pkg::HE_W-1:0]   he;

	assign lin = rbp_pkg::LIN_W'(stage.row) * rbp_pkg::LIN_W'(rbp_pkg::LINE_PIXELS)
		+ rbp_pkg::LIN_W'(stage.col);
	assign col_prev = stage.col - rbp_pkg::POS_W'(1);
	assign out_cur  = (rbp_pkg::CMP_W'(stage.col) >= rbp_pkg::CMP_W'(rbp_pkg::LINE_PIXELS))
		|| (rbp_pkg::CMP_W'(stage.row) >= rbp_pkg::CMP_W'(rbp_pkg::FRAME_LINES));
	assign out_prev = (rbp_pkg::CMP_W'(col_prev) >= rbp_pkg::CMP_W'(rbp_pkg::LINE_PIXELS))
		|| (rbp_pkg::CMP_W'(stage.row) >= rbp_pkg::CMP_W'(rbp_pkg::FRAME_LINES));
	assign odd = stage.col[0];

	always_comb begin
		if (stage.pair) begin
			data = {stage.pixel, stage.held_pixel};
			he   = rbp_pkg::HE_BOTH;
		end else if (odd) begin
			data = {stage.pixel, {rbp_pkg::PIX_W{1'b0}}};
			he   = rbp_pkg::HE_HIGH;
		end else begin
			data = {{rbp_pkg::PIX_W{1'b0}}, stage.pixel};
			he   = rbp_pkg::HE_LOW;
		end
	end

	assign stage_ready = !out_valid_q || words.ready;
	assign move        = stage_valid && stage_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= stage.emit;
		end else if (words.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			word_index_q  <= lin[rbp_pkg::WIDX_W:1];
			word_data_q   <= data;
			half_enable_q <= he;
			outside_q     <= out_cur || (stage.pair && out_prev);
			last_q        <= stage.last;
		end
	end

	assign words.valid         = out_valid_q;
	assign words.word_index    = word_index_q;
	assign words.word_data     = word_data_q;
	assign words.half_enable   = half_enable_q;
	assign words.outside_frame = outside_q;
	assign words.last_write    = last_q;

endmodule

// File: rtl/rgb565_rect_blit_packer.sv
// Packs a row-major stream of RGB565 pixels for a configured rectangle into 32-bit
// framebuffer word writes, two pixels to a word with the even column in the low half.
// A pixel is taken in every cycle unless a write that waits to be taken stalls the flow.
// The pixel that completes a write passes the stage register of the column and row
// walker, then the output register of the address and data packer; while a write waits,
// an empty walker stage register can still take a new pixel. An even-column pixel that
// is not at the row end gives no write of its own but is held for its odd neighbor.
// Lone edge pixels give half-word writes with half_enable, and writes beyond the frame
// are flagged with outside_frame. Registers may be written only while the block is idle.
module rgb565_rect_blit_packer (
	input  logic                        clk,
	input  logic                        arst_n,
	rbp_pixel_if.sink                   pixels,
	rbp_word_if.source                  words,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [rbp_pkg::CFG_W-1:0]   cfg_data
);

	logic            stage_valid;
	logic            stage_ready;
	rbp_pkg::stage_t stage;

	rbp_walker u_walker (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixels      (pixels),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.stage_valid (stage_valid),
		.stage_ready (stage_ready),
		.stage       (stage)
	);

	rbp_packer u_packer (
		.clk         (clk),
		.arst_n      (arst_n),
		.stage_valid (stage_valid),
		.stage_ready (stage_ready),
		.stage       (stage),
		.words       (words)
	);

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int ITEM_TARGET = 1900;
	localparam int STALL_LIMIT = 2000;

	typedef struct packed {
		logic [rbp_pkg::WIDX_W-1:0] index;
		logic [rbp_pkg::WORD_W-1:0] data;
		logic [rbp_pkg::HE_W-1:0]   enables;
		logic                       outside;
		logic                       last;
	} word_write_t;

	class blit_scoreboard;
		int unsigned org_x, org_y, width_reg, height_reg;
		int unsigned col_cnt, row_cnt;
		logic [rbp_pkg::PIX_W-1:0] held_pix;
		bit held_ok;
		word_write_t expected_words[$];
		int unsigned mismatches, words_seen, full_words, low_halves, high_halves;
		int unsigned beyond_frame, rect_ends, restarts;

		function new();
			org_x = 0;
			org_y = 0;
			width_reg = 1;
			height_reg = 1;
			col_cnt = 0;
			row_cnt = 0;
			held_pix = '0;
			held_ok = 1'b0;
		endfunction

		function void set_reg(rbp_pkg::cfg_reg_t idx, int unsigned val);
			case (idx)
			rbp_pkg::CFG_ORIGIN_X: org_x = val & 32'h3FF;
			rbp_pkg::CFG_ORIGIN_Y: org_y = val & 32'h3FF;
			rbp_pkg::CFG_RECT_WIDTH: width_reg = val & 32'h7FF;
			rbp_pkg::CFG_RECT_HEIGHT: height_reg = val & 32'h7FF;
			endcase
		endfunction

		function int unsigned side(int unsigned v);
			if (v == 0)
				return 1;
			if (v > rbp_pkg::MAX_SIDE)
				return rbp_pkg::MAX_SIDE;
			return v;
		endfunction

		function logic [rbp_pkg::WIDX_W-1:0] word_at(int unsigned row, int unsigned col);
			int unsigned lin;
			lin = row * rbp_pkg::LINE_PIXELS + col;
			return rbp_pkg::WIDX_W'(lin >> 1);
		endfunction

		function bit off_frame(int unsigned row, int unsigned col);
			return col >= rbp_pkg::LINE_PIXELS || row >= rbp_pkg::FRAME_LINES;
		endfunction

		function void note_pixel(logic [rbp_pkg::PIX_W-1:0] pix, logic restart);
			int unsigned w, h, col, row;
			bit row_end, rect_end;
			word_write_t wr;
			w = side(width_reg);
			h = side(height_reg);
			if (restart) begin
				col_cnt = 0;
				row_cnt = 0;
				held_ok = 1'b0;
				restarts++;
			end
			col = org_x + col_cnt;
			row = org_y + row_cnt;
			row_end = (col_cnt + 1) >= w;
			rect_end = row_end && (row_cnt + 1) >= h;
			wr.index = word_at(row, col);
			wr.last = rect_end;
			if (col % 2 == 0) begin
				if (row_end) begin
					wr.data = {{rbp_pkg::PIX_W{1'b0}}, pix};
					wr.enables = rbp_pkg::HE_LOW;
					wr.outside = off_frame(row, col);
					expected_words.push_back(wr);
					held_ok = 1'b0;
				end else begin
					held_pix = pix;
					held_ok = 1'b1;
				end
			end else begin
				if (held_ok) begin
					wr.data = {pix, held_pix};
					wr.enables = rbp_pkg::HE_BOTH;
					wr.outside = off_frame(row, col) || off_frame(row, col - 1);
				end else begin
					wr.data = {pix, {rbp_pkg::PIX_W{1'b0}}};
					wr.enables = rbp_pkg::HE_HIGH;
					wr.outside = off_frame(row, col);
				end
				expected_words.push_back(wr);
				held_ok = 1'b0;
			end
			if (row_end) begin
				col_cnt = 0;
				row_cnt = rect_end ? 0 : (row_cnt + 1) & 32'h3FF;
			end else begin
				col_cnt = (col_cnt + 1) & 32'h3FF;
			end
		endfunction

		function void check_word(logic [rbp_pkg::WIDX_W-1:0] index,
				logic [rbp_pkg::WORD_W-1:0] data, logic [rbp_pkg::HE_W-1:0] enables,
				logic outside, logic last);
			word_write_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("[%0t] write with nothing pending: idx=%h data=%h he=%b out=%b last=%b",
						$realtime, index, data, enables, outside, last);
				return;
			end
			want = expected_words.pop_front();
			words_seen++;
			if (index !== want.index || data !== want.data || enables !== want.enables ||
					outside !== want.outside || last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] write mismatch: expected idx=%h data=%h he=%b out=%b last=%b",
						$realtime, want.index, want.data, want.enables, want.outside, want.last);
					$display("[%0t]                 actual   idx=%h data=%h he=%b out=%b last=%b",
						$realtime, index, data, enables, outside, last);
				end
				return;
			end
			case (want.enables)
			rbp_pkg::HE_BOTH: full_words++;
			rbp_pkg::HE_LOW: low_halves++;
			default: high_halves++;
			endcase
			if (want.outside)
				beyond_frame++;
			if (want.last)
				rect_ends++;
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [rbp_pkg::CFG_W-1:0] cfg_data;

	rbp_pixel_if pix_if();
	rbp_word_if word_if();

	blit_scoreboard sb = new();
	int unsigned pixels_sent = 0;
	int unsigned stuck_cycles = 0;
	bit quiet = 1'b0;

	rgb565_rect_blit_packer dut (
		.clk(clk),
		.arst_n(arst_n),
		.pixels(pix_if),
		.words(word_if),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic send_pixel(input logic [rbp_pkg::PIX_W-1:0] value, input logic restart);
		int unsigned gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			pix_if.valid <= 1'b0;
			gap = $urandom_range(1, 19);
			repeat (gap) @(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.pixel_value <= value;
		pix_if.first_pixel <= restart;
		do @(posedge clk); while (pix_if.ready !== 1'b1);
		sb.note_pixel(value, restart);
		pixels_sent++;
	endtask

	// A pixel that completes no word may still sit in the walker when the queue runs dry.
	task automatic settle_block();
		pix_if.valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input int unsigned ox, input int unsigned oy,
			input int unsigned w, input int unsigned h, input logic [3:0] sel);
		int unsigned vals[4];
		rbp_pkg::cfg_reg_t idx;
		vals = '{ox, oy, w, h};
		for (int i = 0; i < 4; i++) begin
			if (sel[i]) begin
				idx = rbp_pkg::cfg_reg_t'(i);
				cfg_we <= 1'b1;
				cfg_index <= idx;
				cfg_data <= rbp_pkg::CFG_W'(vals[i]);
				@(posedge clk);
				sb.set_reg(idx, vals[i]);
			end
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [rbp_pkg::PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		default: return rbp_pkg::PIX_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic int unsigned pick_origin();
		case ($urandom_range(0, 7))
		0: return 0;
		1: return 1023;
		2: return $urandom_range(1024, 2047);
		default: return $urandom_range(0, 1023);
		endcase
	endfunction

	function automatic int unsigned pick_side(int unsigned usual_max);
		case ($urandom_range(0, 15))
		0: return 0;
		1: return 2047;
		2: return 1024;
		3: return $urandom_range(1025, 2047);
		4: return $urandom_range(10, 1023);
		default: return $urandom_range(1, usual_max);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && word_if.valid && word_if.ready)
			sb.check_word(word_if.word_index, word_if.word_data, word_if.half_enable,
				word_if.outside_frame, word_if.last_write);
	end

	always @(posedge clk) begin
		if ((pix_if.valid && pix_if.ready) || (word_if.valid && word_if.ready))
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
		if (stuck_cycles >= STALL_LIMIT) begin
			$display("Timed out after %0d cycles without a transfer.", stuck_cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		int unsigned run;
		word_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
			word_if.ready <= 1'b1;
			repeat (run) @(posedge clk);
			if (!quiet) begin
				word_if.ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
		end
	end

	initial begin
		int unsigned ox, oy, w, h, area, len, reps;
		logic [3:0] sel;
		bit fresh;
		arst_n <= 1'b0;
		pix_if.valid <= 1'b0;
		pix_if.pixel_value <= '0;
		pix_if.first_pixel <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= rbp_pkg::CFG_ORIGIN_X;
		cfg_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_pixel(16'h0000, 1'b1);
		send_pixel(16'hFFFF, 1'b0);
		settle_block();
		program_regs(1, 2, 4, 2, 4'hF);
		send_pixel(16'hFFFF, 1'b1);
		send_pixel(16'h0000, 1'b0);
		send_pixel(16'hA5A5, 1'b0);
		send_pixel(16'h5A5A, 1'b0);
		send_pixel(16'h1234, 1'b0);
		send_pixel(16'h8001, 1'b0);
		send_pixel(16'h7FFE, 1'b0);
		send_pixel(16'hFFFF, 1'b0);
		settle_block();
		program_regs(0, 0, 4, 3, 4'hF);
		send_pixel(16'h1111, 1'b1);
		send_pixel(16'h2222, 1'b0);
		send_pixel(16'h3333, 1'b0);
		send_pixel(16'h4444, 1'b1);
		send_pixel(16'h5555, 1'b0);
		send_pixel(16'h6666, 1'b1);
		settle_block();
		// Shifting the origin leaves the held pixel facing another even column.
		program_regs(1, 0, 0, 0, 4'b0001);
		send_pixel(16'h7777, 1'b0);
		send_pixel(16'h8888, 1'b0);
		settle_block();
		program_regs(0, 0, 2, 0, 4'b0100);
		send_pixel(16'h9999, 1'b0);
		settle_block();
		program_regs(1022, 1023, 2047, 0, 4'hF);
		send_pixel(16'hABCD, 1'b1);
		send_pixel(16'hBCDE, 1'b0);
		send_pixel(16'hCDEF, 1'b0);
		send_pixel(16'hDEF0, 1'b0);
		settle_block();
		program_regs(1023, 0, 0, 2047, 4'b1101);
		send_pixel(16'h0F0F, 1'b1);
		send_pixel(16'hF0F0, 1'b0);

		while (pixels_sent < ITEM_TARGET) begin
			settle_block();
			ox = pick_origin();
			oy = pick_origin();
			w = pick_side(9);
			h = pick_side(6);
			fresh = $urandom_range(0, 4) != 0;
			sel = fresh ? 4'hF : 4'($urandom_range(1, 15));
			program_regs(ox, oy, w, h, sel);
			area = sb.side(sb.width_reg) * sb.side(sb.height_reg);
			reps = $urandom_range(1, 3);
			for (int r = 0; r < reps; r++) begin
				len = (area > 120) ? $urandom_range(20, 120) : area;
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(1, len);
				for (int i = 0; i < len; i++)
					send_pixel(rand_pixel(),
						(i == 0 && (fresh || r > 0)) || $urandom_range(0, 39) == 0);
			end
			quiet = pixels_sent > ITEM_TARGET - 250;
		end

		pix_if.valid <= 1'b0;
		while (sb.expected_words.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d pixels with %0d restarts; checked %0d writes.",
			pixels_sent, sb.restarts, sb.words_seen);
		$display("Good writes: %0d full, %0d low half, %0d high half, %0d off frame, %0d last.",
			sb.full_words, sb.low_halves, sb.high_halves, sb.beyond_frame, sb.rect_ends);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d writes still pending.",
				sb.mismatches, sb.expected_words.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: rgb565_rect_blit_packer.f
rtl/rbp_pkg.sv
rtl/rbp_pixel_if.sv
rtl/rbp_word_if.sv
rtl/rbp_walker.sv
rtl/rbp_packer.sv
rtl/rgb565_rect_blit_packer.sv
tb/sv/tb_top.sv
